@@ design/tlcd_pkg.sv @@
// Package for the text to character LCD command translator.
// Holds the command kinds, the command and run types and fixed character codes.
// Depends on nothing; every other design file imports it.
`default_nettype none

package tlcd_pkg;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_HOME   = 3'd1,
    KIND_LINE2  = 3'd2,
    KIND_SHIFT  = 3'd3,
    KIND_SETPOS = 3'd4,
    KIND_CHAR   = 3'd5,
    KIND_DEGREE = 3'd6
  } cmd_kind_e;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharTilde     = 8'h7E;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharC         = 8'h63;
  localparam logic [7:0] CharF         = 8'h66;
  localparam logic [7:0] CharS         = 8'h73;

  localparam logic [6:0] FirstFieldPos     = 7'd6;
  localparam logic [7:0] SecondFieldOffset = 8'd12;
  localparam logic [7:0] FirstShiftCol     = 8'd16;
  localparam int unsigned MaxCmds          = 3;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] char_code;
    logic [6:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         count;
    cmd_t [MaxCmds-1:0] cmds;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } run_push_t;

endpackage

`default_nettype wire

@@ design/tlcd_front.sv @@
// Front end: accepts text bytes, keeps the cursor and escape state and builds
// the run of commands that each byte causes. Depends on tlcd_pkg.
`default_nettype none

module tlcd_front #(
  parameter int unsigned LINE_LENGTH = 40
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         text_byte_i,
  input  wire logic               ends_write_i,
  output tlcd_pkg::run_push_t     push_o
);
  import tlcd_pkg::*;

  localparam logic [7:0] LineLen  = 8'(LINE_LENGTH);
  localparam logic [7:0] TwoLines = 8'(2 * LINE_LENGTH);

  logic [6:0] cursor_q, cursor_d;
  logic       escape_q, escape_d;
  run_t       run;
  logic [1:0] n;
  logic [7:0] next_pos;

  always_comb begin
    run      = '0;
    n        = 2'd0;
    cursor_d = cursor_q;
    escape_d = escape_q;
    next_pos = {1'b0, cursor_q} + 8'd1;
    if (next_pos == TwoLines) begin
      next_pos = 8'd0;
    end
    if (accept_i) begin
      if (escape_q) begin
        escape_d = 1'b0;
        if (text_byte_i == CharN && {1'b0, cursor_q} < LineLen) begin
          run.cmds[0].kind = KIND_HOME;
          run.cmds[1].kind = KIND_LINE2;
          n                = 2'd2;
          cursor_d         = LineLen[6:0];
        end else if (text_byte_i == CharC || text_byte_i == CharN) begin
          run.cmds[0].kind = KIND_CLEAR;
          n                = 2'd1;
          cursor_d         = 7'd0;
        end else if (text_byte_i == CharF) begin
          run.cmds[0].kind = KIND_SETPOS;
          run.cmds[0].pos  = FirstFieldPos;
          n                = 2'd1;
          cursor_d         = FirstFieldPos;
        end else if (text_byte_i == CharS) begin
          run.cmds[0].kind = KIND_SETPOS;
          run.cmds[0].pos  = 7'(LineLen + SecondFieldOffset);
          n                = 2'd1;
          cursor_d         = 7'(LineLen + SecondFieldOffset);
        end
      end else if (text_byte_i == CharBackslash) begin
        escape_d = !ends_write_i;
      end else begin
        if (cursor_q == 7'd0) begin
          run.cmds[n].kind = KIND_CLEAR;
          n                = n + 2'd1;
        end
        if (text_byte_i == CharTilde) begin
          run.cmds[n].kind = KIND_DEGREE;
        end else begin
          run.cmds[n].kind      = KIND_CHAR;
          run.cmds[n].char_code = text_byte_i;
        end
        n        = n + 2'd1;
        cursor_d = next_pos[6:0];
        if ((next_pos >= FirstShiftCol && next_pos < LineLen) ||
            (next_pos >= LineLen + FirstShiftCol && next_pos < TwoLines)) begin
          run.cmds[n].kind = KIND_SHIFT;
          n                = n + 2'd1;
        end
        if (next_pos == LineLen) begin
          run.cmds[n].kind = KIND_HOME;
          n                = n + 2'd1;
          run.cmds[n].kind = KIND_LINE2;
          n                = n + 2'd1;
        end
      end
    end
    run.count    = n;
    push_o.run   = run;
    push_o.valid = accept_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      escape_q <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      escape_q <= escape_d;
    end
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cursor_q} < TwoLines)
    else $error("cursor left the display range");
`endif

endmodule

`default_nettype wire

@@ design/tlcd_queue.sv @@
// Two-entry queue of command runs between the front and back ends.
// Depends on tlcd_pkg.
`default_nettype none

module tlcd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tlcd_pkg::run_push_t push_i,
  input  wire logic                pop_i,
  output logic                     full_o,
  output logic                     empty_o,
  output tlcd_pkg::run_t           head_o
);
  import tlcd_pkg::*;

  run_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i.valid;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("run queue overflowed");
  a_empty_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o && do_push |=> !empty_o)
    else $error("pushed run was lost");
`endif

endmodule

`default_nettype wire

@@ design/tlcd_back.sv @@
// Back end: steps through each queued run and presents one command at a time
// in an output register. Depends on tlcd_pkg.
`default_nettype none

module tlcd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tlcd_pkg::run_t head_i,
  input  wire logic           head_empty_i,
  output logic                head_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [2:0]          command_kind_o,
  output logic [7:0]          char_code_o,
  output logic [6:0]          target_position_o,
  output logic                last_of_run_o
);
  import tlcd_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  cmd_t       cmd_q;
  logic       last_q;
  logic       load, last;

  assign load       = !head_empty_i && (!valid_q || pop_i);
  assign last       = (idx_q == head_i.count - 2'd1);
  assign head_pop_o = load && last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= head_i.cmds[idx_q];
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign empty_o           = !valid_q;
  assign command_kind_o    = cmd_q.kind;
  assign char_code_o       = cmd_q.char_code;
  assign target_position_o = cmd_q.pos;
  assign last_of_run_o     = last_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3)
    else $error("command index out of range");
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> !head_empty_i)
    else $error("run left the queue before its last command");
`endif

endmodule

`default_nettype wire

@@ design/text_to_char_lcd_commands_top.sv @@
// Top level of the text to character LCD command translator.
// Instantiates tlcd_front, tlcd_queue and tlcd_back; depends on tlcd_pkg.
//
// Text bytes enter through a queue-style port: an item is taken on a clock
// edge with push high and full low. Each byte yields zero to three LCD
// commands, which leave through a second queue-style port: the oldest command
// is on the result ports while empty is low and is taken when pop is high.
// last_of_run_o marks the final command of each byte.
// The front end takes one byte per cycle, while full is low, into a two-entry
// run queue; the back end sends one command per cycle while pop is high. A
// byte's first command is written into the run queue and then loaded into
// the output register before it is visible. Bytes causing no command
// produce nothing.
// When the receiver stalls, the output register holds its command, the run
// queue fills and full rises once the queue holds two runs.
// Reset clears the cursor to zero, the escape flag and the queue, and marks the output empty.
`default_nettype none

module text_to_char_lcd_commands_top #(
  parameter int unsigned LINE_LENGTH = 40
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       ends_write_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      command_kind_o,
  output logic [7:0]      char_code_o,
  output logic [6:0]      target_position_o,
  output logic            last_of_run_o
);
  import tlcd_pkg::*;

  run_push_t run_push;
  run_t      head;
  logic      head_empty, head_pop;

  tlcd_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !full),
    .text_byte_i (text_byte_i),
    .ends_write_i(ends_write_i),
    .push_o      (run_push)
  );

  tlcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (run_push),
    .pop_i  (head_pop),
    .full_o (full),
    .empty_o(head_empty),
    .head_o (head)
  );

  tlcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_empty_i     (head_empty),
    .head_pop_o       (head_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .command_kind_o   (command_kind_o),
    .char_code_o      (char_code_o),
    .target_position_o(target_position_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

`default_nettype wire

@@ test/text_to_char_lcd_commands_top_test.sv @@
// Self-checking testbench for text_to_char_lcd_commands_top: text bytes go in, LCD commands are
// predicted from a cursor and escape model and compared with each item popped from the block.
// Depends on tlcd_pkg and the design files under design/.
module text_to_char_lcd_commands_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tlcd_pkg::*;

  localparam int LineLen = 40;

  typedef struct {
    cmd_kind_e  kind;
    logic [7:0] char_code;
    logic [6:0] pos;
    logic       last;
  } lcd_cmd_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic [7:0] text_byte_i = 8'h00;
  logic       ends_write_i = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] command_kind_o;
  logic [7:0] char_code_o;
  logic [6:0] target_position_o;
  logic       last_of_run_o;

  lcd_cmd_t   expected_cmds[$];
  logic [6:0] cursor_pos = '0;
  logic       escape_armed = 1'b0;
  int         mismatch_count = 0;
  bit         sender_gaps = 1'b0;
  bit         receiver_gaps = 1'b0;
  bit         pop_hold_req = 1'b0;
  int         hold_left = 0;
  int         stall_left = 0;

  text_to_char_lcd_commands_top #(
    .LINE_LENGTH(LineLen)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .text_byte_i      (text_byte_i),
    .ends_write_i     (ends_write_i),
    .empty            (empty),
    .pop              (pop),
    .command_kind_o   (command_kind_o),
    .char_code_o      (char_code_o),
    .target_position_o(target_position_o),
    .last_of_run_o    (last_of_run_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic lcd_cmd_t make_cmd(cmd_kind_e k, logic [7:0] c, logic [6:0] p);
    lcd_cmd_t cmd;
    cmd.kind      = k;
    cmd.char_code = c;
    cmd.pos       = p;
    cmd.last      = 1'b0;
    return cmd;
  endfunction

  task automatic translate_byte(input logic [7:0] b, input logic ends);
    lcd_cmd_t run_cmds[$];
    int       next_pos;
    if (escape_armed) begin
      escape_armed = 1'b0;
      if (b == CharN && cursor_pos < LineLen) begin
        run_cmds.push_back(make_cmd(KIND_HOME, 8'h00, 7'd0));
        run_cmds.push_back(make_cmd(KIND_LINE2, 8'h00, 7'd0));
        cursor_pos = 7'(LineLen);
      end else if (b == CharC || b == CharN) begin
        run_cmds.push_back(make_cmd(KIND_CLEAR, 8'h00, 7'd0));
        cursor_pos = 7'd0;
      end else if (b == CharF) begin
        run_cmds.push_back(make_cmd(KIND_SETPOS, 8'h00, FirstFieldPos));
        cursor_pos = FirstFieldPos;
      end else if (b == CharS) begin
        run_cmds.push_back(make_cmd(KIND_SETPOS, 8'h00, 7'(LineLen + 12)));
        cursor_pos = 7'(LineLen + 12);
      end
    end else if (b == CharBackslash) begin
      escape_armed = !ends;
    end else begin
      if (cursor_pos == 7'd0) run_cmds.push_back(make_cmd(KIND_CLEAR, 8'h00, 7'd0));
      if (b == CharTilde) run_cmds.push_back(make_cmd(KIND_DEGREE, 8'h00, 7'd0));
      else run_cmds.push_back(make_cmd(KIND_CHAR, b, 7'd0));
      next_pos = int'(cursor_pos) + 1;
      if (next_pos >= 2 * LineLen) next_pos = 0;
      cursor_pos = 7'(next_pos);
      if ((next_pos >= 16 && next_pos < LineLen) ||
          (next_pos >= LineLen + 16 && next_pos < 2 * LineLen)) begin
        run_cmds.push_back(make_cmd(KIND_SHIFT, 8'h00, 7'd0));
      end
      if (next_pos == LineLen) begin
        run_cmds.push_back(make_cmd(KIND_HOME, 8'h00, 7'd0));
        run_cmds.push_back(make_cmd(KIND_LINE2, 8'h00, 7'd0));
      end
    end
    if (run_cmds.size() > 0) run_cmds[$].last = 1'b1;
    foreach (run_cmds[i]) expected_cmds.push_back(run_cmds[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic ends);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    text_byte_i  <= b;
    ends_write_i <= ends;
    push         <= 1'b1;
    do @(posedge clk_i); while (full);
    translate_byte(b, ends);
  endtask

  task automatic send_escape(input logic [7:0] letter, input logic ends);
    send_byte(CharBackslash, 1'b0);
    send_byte(letter, ends);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 5))
      0, 1:    return CharN;
      2:       return CharC;
      3:       return CharF;
      4:       return CharS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_escapes();
    send_escape(CharN, 1'b0);
    send_escape(CharN, 1'b0);
    send_escape(CharC, 1'b0);
    send_escape(CharF, 1'b0);
    send_escape(CharS, 1'b0);
    send_escape(8'h71, 1'b0);
    send_escape(CharBackslash, 1'b0);
    send_byte(CharBackslash, 1'b1);
    send_byte(CharC, 1'b1);
    send_escape(CharC, 1'b0);
    send_byte(CharTilde, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_escape(CharN, 1'b1);
  endtask

  // Walks the cursor across both lines, through the shift ranges and the wrap back to zero.
  task automatic test_line_wrap();
    logic [7:0] b;
    send_escape(CharC, 1'b0);
    repeat (2 * LineLen + 3) begin
      b = 8'($urandom_range(8'h20, 8'h7D));
      if (b == CharBackslash) b = 8'h2F;
      send_byte(b, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_full_stall();
    bit gaps_were;
    gaps_were   = sender_gaps;
    sender_gaps = 1'b0;
    wait_drained();
    pop_hold_req = 1'b1;
    repeat (30) send_byte(8'($urandom_range(8'h20, 8'h7D)), 1'b0);
    wait_drained();
    sender_gaps = gaps_were;
  endtask

  task automatic test_random_text(input int rounds, input int quiet_from);
    int r;
    for (int i = 0; i < rounds; i++) begin
      if (i == quiet_from) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      r = $urandom_range(0, 9);
      if (r < 2) send_escape(pick_letter(), 1'($urandom_range(0, 1)));
      else if (r == 2) send_byte(CharBackslash, 1'b1);
      else if (r == 3) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (r == 4) send_byte(CharTilde, 1'($urandom_range(0, 1)));
      else send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'($urandom_range(0, 1)));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold_req) begin
      pop_hold_req = 1'b0;
      hold_left    = 60;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    lcd_cmd_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("command with none pending, kind", command_kind_o, -1);
      end else begin
        want = expected_cmds.pop_front();
        if (command_kind_o !== want.kind) report_mismatch("command_kind", command_kind_o, want.kind);
        if (char_code_o !== want.char_code) report_mismatch("char_code", char_code_o, want.char_code);
        if (target_position_o !== want.pos) report_mismatch("target_position", target_position_o, want.pos);
        if (last_of_run_o !== want.last) report_mismatch("last_of_run", last_of_run_o, want.last);
      end
    end
  end

  initial begin
    #400000;
    $display("text_to_char_lcd_commands_top test failed");
    $finish;
  end

  initial begin : run_tests
    int waited;
    waited = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_escapes();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    test_line_wrap();
    test_full_stall();
    test_random_text(45, 30);
    push <= 1'b0;
    while (expected_cmds.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_cmds.size() != 0) report_mismatch("commands never delivered", 0, expected_cmds.size());
    if (mismatch_count == 0) begin
      $display("text_to_char_lcd_commands_top test passed");
    end else begin
      $display("text_to_char_lcd_commands_top test failed");
    end
    $finish;
  end

endmodule
